// ----- src/wstd_pkg.sv -----
// Package for the weighted server task dispatcher: widths, register map,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package wstd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = $clog2(MAX_SERVERS);

    localparam int SLOT_W      = 4;
    localparam int WEIGHT_W    = 16;
    localparam int DUR_W       = 16;
    localparam int OUT_W       = 4;
    localparam int CNT_W       = 5;
    localparam int TIME_W      = 48;
    localparam int CLOCK_W     = 32;

    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index, taken from paddr[2] (byte address 4*i)
    localparam logic REG_SERVER_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] SERVER_COUNT_RESET = CNT_W'(MAX_SERVERS);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TASK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } wstd_state_t;

    typedef struct packed {
        logic load;
        logic task_start;
        logic scan_rd;
        logic commit;
    } wstd_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } wstd_stat_t;

endpackage

`default_nettype wire

// ----- src/wstd_ctrl.sv -----
// Controller for the dispatcher: accepts items, sequences the server scan
// and the write-back. Depends on wstd_pkg.
`default_nettype none

module wstd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic               in_action,
    output logic                    in_ready,
    input  wire wstd_pkg::wstd_stat_t stat,
    output wstd_pkg::wstd_cmd_t     cmd
);

    wstd_pkg::wstd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wstd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            wstd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_action == wstd_pkg::ACT_TASK) begin
                        cmd.task_start = 1'b1;
                        state_next     = wstd_pkg::ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            wstd_pkg::ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last) begin
                    state_next = wstd_pkg::ST_DRAIN;
                end
            end
            // last entry is compared here
            wstd_pkg::ST_DRAIN: begin
                state_next = wstd_pkg::ST_COMMIT;
            end
            wstd_pkg::ST_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = wstd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wstd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/wstd_dpath.sv -----
// Datapath for the dispatcher: weight memory, free-time table, task clock,
// scan comparator and the output register. Depends on wstd_pkg.
`default_nettype none

module wstd_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire wstd_pkg::wstd_cmd_t               cmd,
    output wstd_pkg::wstd_stat_t                   stat,
    input  wire logic [wstd_pkg::SLOT_W-1:0]       in_slot,
    input  wire logic [wstd_pkg::WEIGHT_W-1:0]     in_weight,
    input  wire logic [wstd_pkg::DUR_W-1:0]        in_duration,
    input  wire logic [wstd_pkg::CNT_W-1:0]        server_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [wstd_pkg::OUT_W-1:0]             out_server
);

    localparam int IDX_W    = wstd_pkg::IDX_W;
    localparam int TIME_W   = wstd_pkg::TIME_W;
    localparam int WEIGHT_W = wstd_pkg::WEIGHT_W;
    localparam int CLOCK_W  = wstd_pkg::CLOCK_W;
    localparam int NSRV     = wstd_pkg::MAX_SERVERS;

    logic [WEIGHT_W-1:0] weight_mem [NSRV];
    logic [TIME_W-1:0]   free_time_reg [NSRV];
    logic [NSRV-1:0]     free_vld_reg;

    logic [CLOCK_W-1:0]        clock_reg;
    logic [wstd_pkg::DUR_W-1:0] dur_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [WEIGHT_W-1:0] rd_weight_reg;
    logic [TIME_W-1:0]   rd_time_reg;

    logic                have_free_reg;
    logic [IDX_W-1:0]    bf_idx_reg;
    logic [WEIGHT_W-1:0] bf_weight_reg;
    logic [IDX_W-1:0]    bb_idx_reg;
    logic [TIME_W-1:0]   bb_time_reg;
    logic [WEIGHT_W-1:0] bb_weight_reg;

    logic                    out_valid_reg;
    logic [wstd_pkg::OUT_W-1:0] out_server_reg;

    logic [IDX_W-1:0]  last_idx;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic [TIME_W-1:0] now;
    logic              is_free;
    logic              take_free;
    logic              take_busy;
    logic [IDX_W-1:0]  pick;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] finish;

    // servers in use: zero counts as one, above the table as the full table
    always_comb begin
        if (server_count == '0) begin
            last_idx = '0;
        end else if (32'(server_count) > NSRV) begin
            last_idx = IDX_W'(NSRV - 1);
        end else begin
            last_idx = IDX_W'(server_count - 1'b1);
        end
    end

    assign slot_ok  = 32'(in_slot) < NSRV;
    assign slot_idx = IDX_W'(in_slot);
    assign now      = TIME_W'(clock_reg);

    assign is_free   = rd_time_reg <= now;
    assign take_free = is_free && (!have_free_reg || rd_weight_reg < bf_weight_reg);
    assign take_busy = (cmp_idx_reg == '0) || (rd_time_reg < bb_time_reg) ||
                       (rd_time_reg == bb_time_reg && rd_weight_reg < bb_weight_reg);

    // a free pick starts now; otherwise every server is busy past now
    assign pick   = have_free_reg ? bf_idx_reg : bb_idx_reg;
    assign start  = have_free_reg ? now : bb_time_reg;
    assign sum    = {1'b0, start} + (TIME_W + 1)'(dur_reg);
    assign finish = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign stat.scan_last = scan_idx_reg == last_idx;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_server = out_server_reg;

    // weight memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && slot_ok) begin
            weight_mem[slot_idx] <= in_weight;
        end
        rd_weight_reg <= weight_mem[scan_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && slot_ok) begin
            free_time_reg[slot_idx] <= '0;
        end else if (cmd.commit) begin
            free_time_reg[pick] <= finish;
        end
        rd_time_reg <= free_vld_reg[scan_idx_reg] ? free_time_reg[scan_idx_reg] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_vld_reg  <= '0;
            clock_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && slot_ok) begin
                free_vld_reg[slot_idx] <= 1'b1;
            end else if (cmd.commit) begin
                free_vld_reg[pick] <= 1'b1;
            end
            cmp_vld_reg <= cmd.scan_rd;
            if (cmd.commit) begin
                if (clock_reg != {CLOCK_W{1'b1}}) begin
                    clock_reg <= clock_reg + 1'b1;
                end
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.task_start) begin
            dur_reg       <= in_duration;
            scan_idx_reg  <= '0;
            have_free_reg <= 1'b0;
        end else if (cmd.scan_rd) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_vld_reg) begin
            if (take_free) begin
                have_free_reg <= 1'b1;
                bf_idx_reg    <= cmp_idx_reg;
                bf_weight_reg <= rd_weight_reg;
            end
            if (take_busy) begin
                bb_idx_reg    <= cmp_idx_reg;
                bb_time_reg   <= rd_time_reg;
                bb_weight_reg <= rd_weight_reg;
            end
        end
        if (cmd.commit) begin
            out_server_reg <= wstd_pkg::OUT_W'(pick);
        end
    end

endmodule

`default_nettype wire

// ----- src/weighted_server_task_dispatcher.sv -----
// Top level of the weighted server task dispatcher: stream ports, APB register
// and the controller/datapath pair. Depends on wstd_pkg, wstd_ctrl, wstd_dpath.
//
//   channel   | ports              | carries
//   ----------+--------------------+-------------------------------------------
//   s_ input  | s_tvalid/tready    | tuser: action; tdata: slot, weight, duration
//   m_ result | m_tvalid/tready    | tdata: assigned_server (one per task)
//   apb cfg   | psel/penable/...   | server_count at byte address 0
//
// A load transaction is accepted in idle. A task is accepted, then scans n servers, n
// being server_count held to 1..16, one at a time through the single weight-memory read
// port and comparator, drains the last compare, writes back; s_tready stays low meanwhile.
// Reset clears the free times, task clock and server_count (to 16); weights
// are undefined until loaded. A stalled result holds the block in write-back.
`default_nettype none

module weighted_server_task_dispatcher (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [3:0] server_slot, [19:4] server_weight, [35:20] task_duration, [39:36] zero
    input  wire logic [wstd_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] action
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [3:0] assigned_server, [7:4] zero
    output logic [wstd_pkg::OUT_DATA_W-1:0]           m_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [wstd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [wstd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wstd_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    logic [wstd_pkg::CNT_W-1:0] server_count_reg;
    logic [wstd_pkg::OUT_W-1:0] out_server;
    wstd_pkg::wstd_cmd_t        cmd;
    wstd_pkg::wstd_stat_t       stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_count_reg <= wstd_pkg::SERVER_COUNT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == wstd_pkg::REG_SERVER_COUNT) begin
            server_count_reg <= pwdata[wstd_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == wstd_pkg::REG_SERVER_COUNT) begin
            prdata = wstd_pkg::APB_DATA_W'(server_count_reg);
        end
    end

    wstd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wstd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_slot      (s_tdata[3:0]),
        .in_weight    (s_tdata[19:4]),
        .in_duration  (s_tdata[35:20]),
        .server_count (server_count_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_server   (out_server)
    );

    assign m_tdata = wstd_pkg::OUT_DATA_W'(out_server);

endmodule

`default_nettype wire

// ----- sim/wstd_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the weighted server task dispatcher: tracks server_count writes on the
// APB port, predicts the server picked for every task transaction, checks the result stream.
// Depends on wstd_pkg.
module wstd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [wstd_pkg::IN_DATA_W-1:0]    s_tdata,   // slot, weight, duration, pad
    input  logic                              s_tuser,   // action
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [wstd_pkg::OUT_DATA_W-1:0]   m_tdata,   // assigned_server, pad
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wstd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wstd_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                outstanding
);
    import wstd_pkg::*;

    logic [WEIGHT_W-1:0] weight_mem [MAX_SERVERS];
    logic [TIME_W-1:0]   free_at [MAX_SERVERS];
    logic [CLOCK_W-1:0]  task_now;
    logic [CNT_W-1:0]    srv_count;
    logic [OUT_W-1:0]    assigned_q [$];

    function automatic int servers_active();
        if (srv_count == 0) return 1;
        if (srv_count > MAX_SERVERS) return MAX_SERVERS;
        return int'(srv_count);
    endfunction

    // Picks a server for one task and books its free time.
    task automatic dispatch(input logic [DUR_W-1:0] dur, output logic [OUT_W-1:0] pick);
        int                n;
        int                pick_free;
        int                pick_busy;
        bit                found_free;
        int                sel;
        logic [TIME_W-1:0] busy_from;
        logic [TIME_W:0]   busy_until;
        n          = servers_active();
        pick_free  = 0;
        pick_busy  = 0;
        found_free = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (free_at[i] <= TIME_W'(task_now)) begin
                if (!found_free || weight_mem[i] < weight_mem[pick_free]) begin
                    pick_free  = i;
                    found_free = 1'b1;
                end
            end
            if (i != 0 && (free_at[i] < free_at[pick_busy] ||
                           (free_at[i] == free_at[pick_busy] &&
                            weight_mem[i] < weight_mem[pick_busy])))
                pick_busy = i;
        end
        sel        = found_free ? pick_free : pick_busy;
        busy_from  = (free_at[sel] > TIME_W'(task_now)) ? free_at[sel] : TIME_W'(task_now);
        busy_until = {1'b0, busy_from} + (TIME_W+1)'(dur);
        free_at[sel] = busy_until[TIME_W] ? {TIME_W{1'b1}} : busy_until[TIME_W-1:0];
        if (task_now != {CLOCK_W{1'b1}})
            task_now = task_now + 1'b1;
        pick = OUT_W'(sel);
    endtask

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            srv_count = SERVER_COUNT_RESET;
            task_now  = '0;
            for (int i = 0; i < MAX_SERVERS; i++)
                free_at[i] = '0;
            assigned_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_SERVER_COUNT)
                srv_count = pwdata[CNT_W-1:0];

            if (m_tvalid && m_tready) begin
                if (assigned_q.size() == 0) begin
                    $error("unexpected result transaction: assigned_server %0d",
                           m_tdata[OUT_W-1:0]);
                    mismatches++;
                end else begin
                    want = assigned_q.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want) begin
                        $error("assigned_server: expected %0d, actual %0d",
                               want, m_tdata[OUT_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[OUT_DATA_W-1:OUT_W] !== '0) begin
                        $error("m_tdata pad: expected 0, actual %0h",
                               m_tdata[OUT_DATA_W-1:OUT_W]);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_LOAD) begin
                    weight_mem[s_tdata[SLOT_W-1:0]] = s_tdata[SLOT_W +: WEIGHT_W];
                    free_at[s_tdata[SLOT_W-1:0]]    = '0;
                end else begin
                    dispatch(s_tdata[SLOT_W+WEIGHT_W +: DUR_W], want);
                    assigned_q = {assigned_q, want};
                end
            end
        end
        outstanding <= assigned_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the dispatcher testbench: clock, reset, APB and stream stimulus with random idling,
// final verdict. Depends on wstd_pkg, weighted_server_task_dispatcher and wstd_checker.
module tb_top;
    import wstd_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = MAX_SERVERS + 8;
    localparam int PHASES = 16;
    localparam int PHASE_ITEMS = 100;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    outstanding;
    int                    cycle_count = 0;
    int                    stall_left = 0;
    bit                    steady = 1'b0;
    int                    in_use = MAX_SERVERS;

    always #2 aclk = ~aclk;

    weighted_server_task_dispatcher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wstd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 15) return '1;
        if (r < 60) return WEIGHT_W'($urandom_range(0, 7));
        return WEIGHT_W'($urandom);
    endfunction

    // short durations keep servers cycling between free and busy
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 80) return DUR_W'($urandom_range(0, 2 * in_use));
        return DUR_W'($urandom);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady)
                stall_left <= idle_len();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_item(input logic act, input logic [SLOT_W-1:0] slot,
                             input logic [WEIGHT_W-1:0] wt, input logic [DUR_W-1:0] dur);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= IN_DATA_W'({dur, wt, slot});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_server(input logic [SLOT_W-1:0] slot, input logic [WEIGHT_W-1:0] wt);
        push_item(ACT_LOAD, slot, wt, DUR_W'($urandom));
    endtask

    task automatic submit_task(input logic [DUR_W-1:0] dur);
        push_item(ACT_TASK, SLOT_W'($urandom), WEIGHT_W'($urandom), dur);
    endtask

    // loads produce no result, so the block may still be busy when the queue empties
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_server_count(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SERVER_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        in_use = (value == 0) ? 1 : (value > MAX_SERVERS) ? MAX_SERVERS : int'(value);
    endtask

    initial begin
        logic [CNT_W-1:0] count;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single server: free pick, then busy pick with itself as the only choice
        write_server_count(CNT_W'(1));
        load_server('0, '1);
        submit_task('0);
        submit_task('1);
        submit_task(DUR_W'(5));
        // fill the rest of the table, slots above server_count included
        for (int i = 1; i < MAX_SERVERS; i++) begin
            if (i == 1 || i == 2)
                load_server(SLOT_W'(i), '0);
            else if (i == MAX_SERVERS - 1)
                load_server(SLOT_W'(i), '1);
            else
                load_server(SLOT_W'(i), WEIGHT_W'(37 * i));
        end
        settle();

        // full table: weight ties, long tasks pushing servers past the task clock
        write_server_count(CNT_W'(MAX_SERVERS));
        submit_task('0);
        submit_task('1);
        submit_task('1);
        submit_task(DUR_W'(1));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = CNT_W'(MAX_SERVERS);
                1:       count = '0;
                2:       count = '1;
                3:       count = CNT_W'(1);
                4:       count = CNT_W'(2);
                default: count = CNT_W'($urandom_range(0, 31));
            endcase
            steady <= (p % 4 == 3);
            write_server_count(count);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 25) begin
                    if ($urandom_range(0, 3) == 0)
                        load_server(SLOT_W'($urandom), pick_weight());
                    else
                        load_server(SLOT_W'($urandom_range(0, in_use - 1)), pick_weight());
                end else begin
                    submit_task(pick_duration());
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
